// ----- hdl/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 stream decoder
// Byte class codes, the classified byte record and field widths.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // Default depth of the queue between classifier and decoder
  localparam int QUEUE_DEPTH = 4;

  // Byte classes
  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_LEAD  = 2'd1;
  localparam logic [1:0] KIND_CONT  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // One classified byte: class, payload bits, continuation bytes to follow, end flag
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] bits;
    logic [1:0] len;
    logic       last;
  } byte_class_t;

endpackage

// ----- hdl/utf8d_byte_if.sv -----
// ----------------------------------------------------------------------------
// utf8d_byte_if: raw byte channel
// Carries one stream byte and its end-of-buffer flag per transfer.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ----- hdl/utf8d_cp_if.sv -----
// ----------------------------------------------------------------------------
// utf8d_cp_if: code point channel
// Carries one decoded code point or an error mark per transfer.
// ----------------------------------------------------------------------------
interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        error;

  modport source (output valid, output code_point, output error, input ready);
  modport sink   (input valid, input code_point, input error, output ready);
endinterface

// ----- hdl/utf8_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core: UTF-8 byte stream to code point decoder
// Bytes come in on "bytes" (valid/ready, data_byte, end_of_buffer); decoded
// code points or error marks leave on "points" (valid/ready, code_point,
// error). A transfer happens at a rising edge with valid and ready high.
// One byte is taken per cycle while the FIFO has room. ASCII bytes and bytes
// that finish a sequence give one result; lead and inner continuation bytes
// give none unless the end flag cuts the sequence short. Illegal bytes give
// an error result with code_point zero, are dropped, and decoding restarts.
// A byte is written into the FIFO at its transfer edge; the decoder then
// pops it and loads its result into the output register. The classifier
// writes a small FIFO (DEPTH entries) read by the decoder, so either side
// can stall alone. When the receiver stalls the output register holds its
// result and the decoder stops popping; bytes are still taken until the
// FIFO fills.
// Synchronous reset empties the FIFO, clears the open sequence and drops
// any pending result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core #(
  parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  utf8d_byte_if.sink  bytes,
  utf8d_cp_if.source  points
);
  import utf8d_pkg::*;

  logic        q_space;
  logic        q_push;
  logic        q_pop;
  logic        q_avail;
  byte_class_t q_in;
  byte_class_t q_head;

  // Classify incoming bytes
  utf8d_front u_front (
    .bytes   (bytes),
    .q_space (q_space),
    .q_push  (q_push),
    .q_item  (q_in)
  );

  // Decouple classifier and decoder
  utf8d_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .space     (q_space),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // Decode sequences and register results
  utf8d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (q_avail),
    .head   (q_head),
    .pop    (q_pop),
    .points (points)
  );

endmodule

// ----- hdl/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// utf8d_front: byte classifier
// Accepts raw bytes and pushes their class and payload bits into the queue.
// ----------------------------------------------------------------------------
module utf8d_front (
  utf8d_byte_if.sink          bytes,
  input  logic                q_space,
  output logic                q_push,
  output utf8d_pkg::byte_class_t q_item
);
  import utf8d_pkg::*;

  // Take a byte whenever the queue has room
  assign bytes.ready = q_space;
  assign q_push      = bytes.valid && q_space;

  // Classify by the leading bits
  always_comb begin
    q_item.last = bytes.end_of_buffer;
    q_item.len  = 2'd0;
    q_item.bits = 7'd0;
    if (!bytes.data_byte[7]) begin
      q_item.kind = KIND_ASCII;
      q_item.bits = bytes.data_byte[6:0];
    end else if (bytes.data_byte[7:6] == 2'b10) begin
      q_item.kind = KIND_CONT;
      q_item.bits = {1'b0, bytes.data_byte[5:0]};
    end else if (bytes.data_byte[7:5] == 3'b110) begin
      q_item.kind = KIND_LEAD;
      q_item.len  = 2'd1;
      q_item.bits = {2'b0, bytes.data_byte[4:0]};
    end else if (bytes.data_byte[7:4] == 4'b1110) begin
      q_item.kind = KIND_LEAD;
      q_item.len  = 2'd2;
      q_item.bits = {3'b0, bytes.data_byte[3:0]};
    end else if (bytes.data_byte[7:3] == 5'b11110) begin
      q_item.kind = KIND_LEAD;
      q_item.len  = 2'd3;
      q_item.bits = {4'b0, bytes.data_byte[2:0]};
    end else begin
      q_item.kind = KIND_BAD;
    end
  end

endmodule

// ----- hdl/utf8d_queue.sv -----
// ----------------------------------------------------------------------------
// utf8d_queue: classified byte queue
// Short FIFO that decouples the classifier from the decoder.
// ----------------------------------------------------------------------------
module utf8d_queue #(
  parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  utf8d_pkg::byte_class_t push_item,
  output logic                   space,
  input  logic                   pop,
  output logic                   avail,
  output utf8d_pkg::byte_class_t head
);
  import utf8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  byte_class_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign space = (count != FULL_CNT);
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !space |-> !push) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !avail |-> !pop) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("queue count out of range");
`endif

endmodule

// ----- hdl/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// utf8d_back: sequence decoder
// Pops classified bytes, tracks the open sequence and registers results.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   avail,
  input  utf8d_pkg::byte_class_t head,
  output logic                   pop,
  utf8d_cp_if.source             points
);
  import utf8d_pkg::*;

  logic [CP_W-1:0] partial;
  logic [CP_W-1:0] partial_next;
  logic [1:0]      pending;
  logic [1:0]      pending_next;
  logic            emit;
  logic [CP_W-1:0] emit_cp;
  logic            emit_err;
  logic            out_valid;
  logic [CP_W-1:0] out_cp;
  logic            out_err;
  logic [CP_W-1:0] shifted;
  logic [1:0]      remaining;

  // Pop when the output register is free or being drained
  assign pop = avail && (!out_valid || points.ready);

  assign shifted   = {partial[CP_W-7:0], head.bits[5:0]};
  assign remaining = pending - 2'd1;

  // Decode one byte against the open sequence
  always_comb begin
    partial_next = partial;
    pending_next = pending;
    emit         = 1'b0;
    emit_cp      = '0;
    emit_err     = 1'b0;
    if (pending == 2'd0) begin
      unique case (head.kind)
        KIND_ASCII: begin
          emit    = 1'b1;
          emit_cp = CP_W'(head.bits);
        end
        KIND_LEAD: begin
          if (head.last) begin
            emit     = 1'b1;
            emit_err = 1'b1;
          end else begin
            partial_next = CP_W'(head.bits);
            pending_next = head.len;
          end
        end
        default: begin
          emit     = 1'b1;
          emit_err = 1'b1;
        end
      endcase
    end else if (head.kind != KIND_CONT) begin
      emit         = 1'b1;
      emit_err     = 1'b1;
      partial_next = '0;
      pending_next = 2'd0;
    end else if (remaining == 2'd0) begin
      emit         = 1'b1;
      emit_cp      = shifted;
      partial_next = '0;
      pending_next = 2'd0;
    end else if (head.last) begin
      emit         = 1'b1;
      emit_err     = 1'b1;
      partial_next = '0;
      pending_next = 2'd0;
    end else begin
      partial_next = shifted;
      pending_next = remaining;
    end
  end

  // Hold sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      pending <= 2'd0;
    end else if (pop) begin
      partial <= partial_next;
      pending <= pending_next;
    end
  end

  // Output register: load on a result, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (points.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_cp  <= emit_cp;
      out_err <= emit_err;
    end
  end

  assign points.valid      = out_valid;
  assign points.code_point = out_cp;
  assign points.error      = out_err;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_cp == '0) else $error("error result with nonzero value");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd0 |-> partial == '0) else $error("stale partial value while idle");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> pending == 2'd0 && !out_valid) else $error("decoder not idle after reset");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !points.ready |-> !pop) else $error("pop while result stalled");
`endif

endmodule

// ----- dv/tb_utf8_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_core: self-checking bench for the UTF-8 decoder
// Feeds directed and random byte streams through the byte channel, predicts
// every code point and error mark, and checks each result transfer against
// the oldest prediction. Both sides idle at random; the receiver also holds
// off for long stretches so that the internal FIFO fills and stalls input.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_core;
  import utf8d_pkg::*;

  localparam int HOLD_CYCLES = 250;
  localparam int HOLD_COUNT  = 2;
  localparam int HOLD_STEP   = 350;
  localparam int QUIET_START = 1200;
  localparam int QUIET_END   = 1900;
  localparam int IDLE_PCT    = 6;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } stream_byte_t;

  typedef struct {
    logic [CP_W-1:0] code_point;
    logic            error;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   cp_ch ();

  utf8_stream_decoder_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .points (cp_ch)
  );

  stream_byte_t pending_bytes[$];
  point_t       expected_points[$];

  // Decoder state as predicted
  logic [CP_W-1:0] seq_value = '0;
  logic [1:0]      seq_left  = '0;

  int unsigned cycle_cnt      = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_cnt       = 0;
  int unsigned hold_starts    = 0;
  logic        hold_off       = 1'b0;

  // Drive every input to a known value from time zero
  initial begin
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = '0;
    byte_ch.end_of_buffer = 1'b0;
    cp_ch.ready           = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic logic idle_now();
    if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------
  task automatic flag_error();
    point_t p;
    p.code_point = '0;
    p.error      = 1'b1;
    seq_value = '0;
    seq_left  = '0;
    expected_points.push_back(p);
  endtask

  task automatic emit_point(input logic [CP_W-1:0] cp);
    point_t p;
    p.code_point = cp;
    p.error      = 1'b0;
    expected_points.push_back(p);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eob);
    logic [CP_W-1:0] next_value;
    next_value = '0;
    if (seq_left == 2'd0) begin
      if (b[7] == 1'b0) begin
        emit_point(CP_W'(b));
      end else if (b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
        // stray continuation or illegal lead: drop it
        flag_error();
      end else begin
        if (b[7:5] == 3'b110) begin
          seq_value = CP_W'(b[4:0]);
          seq_left  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          seq_value = CP_W'(b[3:0]);
          seq_left  = 2'd2;
        end else begin
          seq_value = CP_W'(b[2:0]);
          seq_left  = 2'd3;
        end
        // end flag on a lead byte cuts the sequence short
        if (eob) flag_error();
      end
    end else if (b[7:6] != 2'b10) begin
      // broken sequence: drop the byte and restart
      flag_error();
    end else begin
      next_value = {seq_value[CP_W-7:0], b[5:0]};
      seq_left   = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        seq_value = '0;
        emit_point(next_value);
      end else begin
        seq_value = next_value;
        if (eob) flag_error();
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Driver: offer queued bytes, hold each until it transfers
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    stream_byte_t item;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.data_byte, byte_ch.end_of_buffer);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!(byte_ch.valid && !byte_ch.ready)) begin
        if (pending_bytes.size() > 0 && !idle_now()) begin
          item = pending_bytes.pop_front();
          byte_ch.valid         <= 1'b1;
          byte_ch.data_byte     <= item.data_byte;
          byte_ch.end_of_buffer <= item.end_of_buffer;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver hold-off: up to HOLD_COUNT long stalls, one per HOLD_STEP accepted bytes
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
      hold_off <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 1'b0;
    end else if (hold_starts < HOLD_COUNT &&
                 bytes_accepted >= HOLD_STEP * (hold_starts + 1)) begin
      hold_cnt    <= HOLD_CYCLES;
      hold_off    <= 1'b1;
      hold_starts <= hold_starts + 1;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    point_t      want;
    int unsigned bad;
    bad = 0;
    if (rst) begin
      cp_ch.ready <= 1'b0;
    end else begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result, expected none actual cp %h error %b",
                   $time, cp_ch.code_point, cp_ch.error);
          bad = bad + 1;
        end else begin
          want = expected_points.pop_front();
          if (cp_ch.code_point !== want.code_point) begin
            $display("%0t: code_point mismatch, expected %h actual %h",
                     $time, want.code_point, cp_ch.code_point);
            bad = bad + 1;
          end
          if (cp_ch.error !== want.error) begin
            $display("%0t: error mismatch, expected %b actual %b",
                     $time, want.error, cp_ch.error);
            bad = bad + 1;
          end
        end
      end
      // Count all mismatches of this transfer at once
      if (bad != 0) mismatch_count <= mismatch_count + bad;
      cp_ch.ready <= !hold_off && !idle_now();
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eob);
    stream_byte_t item;
    item.data_byte     = b;
    item.end_of_buffer = eob;
    pending_bytes.push_back(item);
  endtask

  function automatic logic [7:0] rand_lead(input int len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(31));
      3:       return 8'hE0 | 8'($urandom_range(15));
      default: return 8'hF0 | 8'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Well-formed sequence; end flag only on the closing byte
  task automatic push_sequence(input int len);
    logic eob;
    eob = ($urandom_range(9) == 0);
    if (len == 1) begin
      push_byte(8'($urandom_range(127)), eob);
    end else begin
      push_byte(rand_lead(len), 1'b0);
      for (int i = 1; i < len - 1; i++) push_byte(rand_cont(), 1'b0);
      push_byte(rand_cont(), eob);
    end
  endtask

  // Sequence interrupted by a byte that is not a continuation
  task automatic push_broken();
    int len;
    int conts;
    logic [7:0] b;
    len   = $urandom_range(2, 4);
    conts = $urandom_range(0, len - 2);
    push_byte(rand_lead(len), 1'b0);
    for (int i = 0; i < conts; i++) push_byte(rand_cont(), 1'b0);
    do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
    push_byte(b, 1'($urandom_range(1)));
  endtask

  // Sequence cut short by the end flag
  task automatic push_truncated();
    int len;
    int conts;
    len   = $urandom_range(2, 4);
    conts = $urandom_range(0, len - 2);
    push_byte(rand_lead(len), conts == 0);
    for (int i = 0; i < conts; i++) push_byte(rand_cont(), i == conts - 1);
  endtask

  // ------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ------------------------------------------------------------------
  initial begin
    int pick;

    // ASCII extremes, with and without the end flag
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    // two-byte: overlong zero, top value
    push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b1);
    // three-byte: surrogate passes unchecked
    push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    // four-byte: largest payload
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    // stray continuations and illegal leads
    push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b1);
    push_byte(8'hF8, 1'b0); push_byte(8'hFF, 1'b1);
    // broken sequences: ASCII inside, then a new lead inside
    push_byte(8'hC3, 1'b0); push_byte(8'h41, 1'b0);
    push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hC3, 1'b0);
    // truncated: on a lead byte, then on an inner continuation
    push_byte(8'hE2, 1'b1);
    push_byte(8'hF0, 1'b0); push_byte(8'h90, 1'b1);

    // Random part: mostly well-formed text, the rest noise and damage
    while (pending_bytes.size() < 1350) begin
      pick = $urandom_range(99);
      if (pick < 75)      push_sequence($urandom_range(1, 4));
      else if (pick < 85) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (pick < 93) push_broken();
      else                push_truncated();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: every byte sent and every prediction checked
    while (pending_bytes.size() > 0 || byte_ch.valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/utf8d_pkg.sv
hdl/utf8d_byte_if.sv
hdl/utf8d_cp_if.sv
hdl/utf8d_front.sv
hdl/utf8d_queue.sv
hdl/utf8d_back.sv
hdl/utf8_stream_decoder_core.sv
dv/tb_utf8_stream_decoder_core.sv
